[hdl/bbt_pkg.sv]
// ---------------------------------------------------------------------------
// bbt_pkg
// shared widths, defaults and request codes for the blob box tracker table
// ---------------------------------------------------------------------------
package bbt_pkg;

  localparam int MAX_BLOBS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int ID_W           = 32;
  localparam int FRAME_W        = 32;

  typedef enum logic {
    OP_DETECT = 1'b0,
    OP_AGE    = 1'b1
  } bbt_op_t;

endpackage

[hdl/bbt_overlap.sv]
// ---------------------------------------------------------------------------
// bbt_overlap
// exact box overlap test on doubled centre coordinates, touching counts
// ---------------------------------------------------------------------------
module bbt_overlap
  import bbt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] a_x,
  input  logic [COORD_BITS-1:0] a_y,
  input  logic [COORD_BITS-1:0] a_w,
  input  logic [COORD_BITS-1:0] a_h,
  input  logic [COORD_BITS-1:0] b_x,
  input  logic [COORD_BITS-1:0] b_y,
  input  logic [COORD_BITS-1:0] b_w,
  input  logic [COORD_BITS-1:0] b_h,
  output logic                  hit
);

  localparam int SW = COORD_BITS + 2;

  logic [SW-1:0] ax2, bx2, ay2, by2, sx, sy;
  logic          meet_x, meet_y;

  assign ax2 = {1'b0, a_x, 1'b0};
  assign bx2 = {1'b0, b_x, 1'b0};
  assign ay2 = {1'b0, a_y, 1'b0};
  assign by2 = {1'b0, b_y, 1'b0};
  assign sx  = SW'(a_w) + SW'(b_w);
  assign sy  = SW'(a_h) + SW'(b_h);

  // spans meet when each doubled centre lies within the other plus both sizes
  assign meet_x = (ax2 <= bx2 + sx) && (bx2 <= ax2 + sx);
  assign meet_y = (ay2 <= by2 + sy) && (by2 <= ay2 + sy);
  assign hit    = meet_x && meet_y;

endmodule

[hdl/blob_box_tracker_table.sv]
// ---------------------------------------------------------------------------
// blob_box_tracker_table
// table of tracked blob boxes: detect matches, adds or reports full, age requests free
// ---------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  request  | in_* fields                    | accepted when start && !busy
//  result   | out_* fields                   | out_valid, one cycle, no stall
//
// after a request is accepted busy stays high through the scan, drain and
// update states: the slot memory has one read port and is walked one slot per
// cycle, then the drain state ends the last compare and update writes back.
// the result strobe follows in the next cycle, in which a new request is
// already taken; no request is taken while the one before is still busy.
// synchronous reset clears all live flags and the id counter; no clearing pass.
// the receiver cannot stall, results are never held.
module blob_box_tracker_table
  import bbt_pkg::*;
#(
  parameter int MAX_BLOBS  = MAX_BLOBS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [FRAME_W-1:0]             in_frame_number,
  input  logic [COORD_BITS-1:0]          in_center_x,
  input  logic [COORD_BITS-1:0]          in_center_y,
  input  logic [COORD_BITS-1:0]          in_box_width,
  input  logic [COORD_BITS-1:0]          in_box_height,
  output logic                           out_valid,
  output logic                           out_matched,
  output logic                           out_added,
  output logic                           out_table_full,
  output logic [ID_W-1:0]                out_blob_id,
  output logic [COORD_BITS-1:0]          out_prev_x,
  output logic [COORD_BITS-1:0]          out_prev_y,
  output logic [$clog2(MAX_BLOBS+1)-1:0] out_live_count,
  output logic [$clog2(MAX_BLOBS+1)-1:0] out_removed_count
);

  localparam int IDX_W = $clog2(MAX_BLOBS);
  localparam int CNT_W = $clog2(MAX_BLOBS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOBS - 1);

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [FRAME_W-1:0]    frame;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  // slot memory
  slot_t            mem [MAX_BLOBS];
  slot_t            rd_data_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;

  state_t               state_r;
  logic [MAX_BLOBS-1:0] live_r;
  logic [ID_W-1:0]      last_id_r;
  logic [CNT_W-1:0]     live_cnt_r;
  logic [CNT_W-1:0]     removed_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 cmp_vld_r;

  // latched request
  logic                  op_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [COORD_BITS-1:0] x_r, y_r, w_r, h_r;

  // scan results
  logic                  hit_found_r, free_found_r;
  logic [IDX_W-1:0]      hit_idx_r, free_idx_r;
  logic [ID_W-1:0]       hit_id_r;
  logic [COORD_BITS-1:0] hit_px_r, hit_py_r;

  // registered results
  logic                  out_valid_r, out_matched_r, out_added_r, out_full_r;
  logic [ID_W-1:0]       out_id_r;
  logic [COORD_BITS-1:0] out_px_r, out_py_r;
  logic [CNT_W-1:0]      out_live_r, out_removed_r;

  logic            ovl_hit;
  logic            cmp_live;
  logic            stale;
  logic [ID_W-1:0] next_id;

  bbt_overlap #(
    .COORD_BITS(COORD_BITS)
  ) u_overlap (
    .a_x (x_r),
    .a_y (y_r),
    .a_w (w_r),
    .a_h (h_r),
    .b_x (rd_data_r.cx),
    .b_y (rd_data_r.cy),
    .b_w (rd_data_r.w),
    .b_h (rd_data_r.h),
    .hit (ovl_hit)
  );

  assign cmp_live = live_r[cmp_idx_r];
  // stored frame plus one, without wrap, below the request frame
  assign stale    = ({1'b0, rd_data_r.frame} + (FRAME_W+1)'(1)) < {1'b0, frame_r};
  assign next_id  = (last_id_r == '1) ? last_id_r : last_id_r + ID_W'(1);

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = hit_found_r ? hit_idx_r : free_idx_r;
    wr_data.id    = hit_found_r ? hit_id_r : next_id;
    wr_data.cx    = x_r;
    wr_data.cy    = y_r;
    wr_data.w     = w_r;
    wr_data.h     = h_r;
    wr_data.frame = frame_r;
    if (state_r == ST_UPDATE && op_r == OP_DETECT && (hit_found_r || free_found_r)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      last_id_r   <= '0;
      live_cnt_r  <= '0;
      removed_r   <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      // compare stage, one slot behind the memory read
      if (cmp_vld_r) begin
        if (op_r == OP_AGE) begin
          if (cmp_live && stale) begin
            live_r[cmp_idx_r] <= 1'b0;
            removed_r         <= removed_r + CNT_W'(1);
            live_cnt_r        <= live_cnt_r - CNT_W'(1);
          end
        end else if (cmp_live) begin
          if (!hit_found_r && ovl_hit) begin
            hit_found_r <= 1'b1;
            hit_idx_r   <= cmp_idx_r;
            hit_id_r    <= rd_data_r.id;
            hit_px_r    <= rd_data_r.cx;
            hit_py_r    <= rd_data_r.cy;
          end
        end else if (!free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r         <= in_opcode;
            frame_r      <= in_frame_number;
            x_r          <= in_center_x;
            y_r          <= in_center_y;
            w_r          <= in_box_width;
            h_r          <= in_box_height;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            removed_r    <= '0;
            rd_idx_r     <= '0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            rd_idx_r <= '0;
            state_r  <= ST_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          cmp_vld_r <= 1'b0;
          state_r   <= ST_UPDATE;
        end
        ST_UPDATE: begin
          out_valid_r   <= 1'b1;
          out_matched_r <= 1'b0;
          out_added_r   <= 1'b0;
          out_full_r    <= 1'b0;
          out_id_r      <= '0;
          out_px_r      <= '0;
          out_py_r      <= '0;
          out_live_r    <= live_cnt_r;
          out_removed_r <= (op_r == OP_AGE) ? removed_r : '0;
          if (op_r == OP_DETECT) begin
            if (hit_found_r) begin
              out_matched_r <= 1'b1;
              out_id_r      <= hit_id_r;
              out_px_r      <= hit_px_r;
              out_py_r      <= hit_py_r;
            end else if (free_found_r) begin
              out_added_r        <= 1'b1;
              out_id_r           <= next_id;
              out_live_r         <= live_cnt_r + CNT_W'(1);
              live_cnt_r         <= live_cnt_r + CNT_W'(1);
              last_id_r          <= next_id;
              live_r[free_idx_r] <= 1'b1;
            end else begin
              out_full_r <= 1'b1;
            end
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_added         = out_added_r;
  assign out_table_full    = out_full_r;
  assign out_blob_id       = out_id_r;
  assign out_prev_x        = out_px_r;
  assign out_prev_y        = out_py_r;
  assign out_live_count    = out_live_r;
  assign out_removed_count = out_removed_r;

endmodule

[hdl/bbt_checker.sv]
// ---------------------------------------------------------------------------
// bbt_checker
// port-level checks on the blob box tracker table, bound to the top level
// ---------------------------------------------------------------------------
module bbt_checker
  import bbt_pkg::*;
#(
  parameter int MAX_BLOBS  = MAX_BLOBS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic                           out_matched,
  input logic                           out_added,
  input logic                           out_table_full,
  input logic [ID_W-1:0]                out_blob_id,
  input logic [COORD_BITS-1:0]          out_prev_x,
  input logic [COORD_BITS-1:0]          out_prev_y,
  input logic [$clog2(MAX_BLOBS+1)-1:0] out_live_count,
  input logic [$clog2(MAX_BLOBS+1)-1:0] out_removed_count
);

  localparam int CNT_W = $clog2(MAX_BLOBS + 1);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // at most one outcome per result
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_matched, out_added, out_table_full}))
    else $error("more than one outcome flag set");

  // previous centre only comes from a match
  a_prev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_prev_x == '0 && out_prev_y == '0)
    else $error("previous centre reported without a match");

  // a fresh id is never zero, and a dropped box has none
  a_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_added ? (out_blob_id != '0)
                             : (out_table_full ? (out_blob_id == '0) : 1'b1)))
    else $error("blob id inconsistent with outcome");

  // live and removed counts never exceed the table size
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= CNT_W'(MAX_BLOBS)
               && out_removed_count <= CNT_W'(MAX_BLOBS))
    else $error("count beyond table size");

endmodule

bind blob_box_tracker_table bbt_checker #(
  .MAX_BLOBS  (MAX_BLOBS),
  .COORD_BITS (COORD_BITS)
) u_bbt_checker (.*);
